FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the queue depth, the entry and command structs that run along the
// cell chain, and the status codes of a result.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TAG_W = 16;
	localparam int PRI_W = 16;
	localparam int OCC_W = 5;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_REMOVED   = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_UNDERFLOW = 2'd3;

	// one stored job, vld marks an occupied slot
	typedef struct packed {
		logic                    vld;
		logic [TAG_W-1:0]        tag;
		logic signed [PRI_W-1:0] pri;
	} spq_entry_t;

	// command broadcast to every cell in the chain
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic [TAG_W-1:0]        tag;
		logic signed [PRI_W-1:0] pri;
	} spq_cmd_t;

endpackage

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Keeps its own entry, keeps it, takes the new job or takes its upper
// neighbor's entry on insert, and takes its lower neighbor's entry on remove.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::spq_cmd_t   cmd,
	input  spq_pkg::spq_entry_t prev_ent,
	input  logic               prev_gt,
	input  spq_pkg::spq_entry_t next_ent,
	output spq_pkg::spq_entry_t ent,
	output logic               gt
);
	import spq_pkg::*;

	logic                    vld_q;
	logic [TAG_W-1:0]        tag_q;
	logic signed [PRI_W-1:0] pri_q;
	spq_entry_t              ent_q;
	spq_entry_t              ent_d;

	assign ent_q = {vld_q, tag_q, pri_q};

	// stored entry strictly ahead of the new job
	assign gt = ent_q.vld && ($signed(ent_q.pri) > $signed(cmd.pri));

	always_comb begin
		ent_d = ent_q;
		if (cmd.ins) begin
			if (!gt) begin
				if (prev_gt) begin
					ent_d.vld = 1'b1;
					ent_d.tag = cmd.tag;
					ent_d.pri = cmd.pri;
				end else begin
					ent_d = prev_ent;
				end
			end
		end else if (cmd.rem) begin
			ent_d = next_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= ent_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= ent_d.tag;
		pri_q <= ent_d.pri;
	end

	assign ent = ent_q;

endmodule

FILE: design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a sorted cell chain
// Top level: command decode, occupancy count, result register and the chain.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH jobs in a row of cells kept sorted by signed
// priority, the highest at cell 0. No command ever stalls: all
// cells compare the new priority at once and each keeps, takes the new job or
// shifts, so busy never rises and a new start is taken in every cycle. The
// result (status, removed tag and priority, occupancy after the command)
// appears on the cycle after the transfer, with done high for exactly that one
// cycle; it is not held, so the receiver must take it then. Among equal
// priorities the newest job is served first. An insert into a full queue
// reports overflow and a remove from an empty one underflow; neither changes
// the contents. occupancy is the count modulo 32.
module sorted_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             func,
	input  logic [spq_pkg::TAG_W-1:0]        job_tag,
	input  logic signed [spq_pkg::PRI_W-1:0] priority_req,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [spq_pkg::TAG_W-1:0]        out_tag,
	output logic signed [spq_pkg::PRI_W-1:0] out_priority,
	output logic [spq_pkg::OCC_W-1:0]        occupancy
);
	import spq_pkg::*;

	// command and count
	logic             xfer;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	spq_cmd_t         cmd;

	// chain wiring
	spq_entry_t       ent   [DEPTH];
	logic             gt    [DEPTH];

	// result register
	logic                    done_q;
	logic [1:0]              status_q;
	logic [TAG_W-1:0]        tag_q;
	logic signed [PRI_W-1:0] pri_q;
	logic [CNT_W-1:0]        occ_q;
	logic [1:0]              status_d;

	// no command ever stalls, so busy is tied low
	assign busy  = 1'b0;
	assign xfer  = start && !busy;
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	assign cmd.ins = xfer && !func && !full;
	assign cmd.rem = xfer && func && !empty;
	assign cmd.tag = job_tag;
	assign cmd.pri = priority_req;

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.ins) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (cmd.rem) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		if (!func) begin
			status_d = full ? ST_OVERFLOW : ST_INSERTED;
		end else begin
			status_d = empty ? ST_UNDERFLOW : ST_REMOVED;
		end
	end

	// the chain: cell 0 is the head, neighbors beyond the ends read as empty
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_entry_t prev_ent;
		spq_entry_t next_ent;
		logic       prev_gt;

		if (i == 0) begin : g_head
			assign prev_ent = '0;
			assign prev_gt  = 1'b1;
		end else begin : g_mid
			assign prev_ent = ent[i-1];
			assign prev_gt  = gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_ent = '0;
		end else begin : g_body
			assign next_ent = ent[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.prev_ent (prev_ent),
			.prev_gt  (prev_gt),
			.next_ent (next_ent),
			.ent      (ent[i]),
			.gt       (gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= xfer;
		end
	end

	// result payload, head entry only reported on a real remove
	always_ff @(posedge clk) begin
		if (xfer) begin
			status_q <= status_d;
			occ_q    <= cnt_d;
			if (cmd.rem) begin
				tag_q <= ent[0].tag;
				pri_q <= ent[0].pri;
			end else begin
				tag_q <= '0;
				pri_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_tag      = tag_q;
	assign out_priority = pri_q;
	assign occupancy    = OCC_W'(occ_q);

	// head is occupied exactly when the count is nonzero
	a_head_vld: assert property (@(posedge clk) disable iff (!arst_n)
		ent[0].vld == (cnt_q != '0))
		else $error("head valid disagrees with count");

	// the two front cells stay in priority order
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(ent[0].vld && ent[1].vld) |-> ($signed(ent[0].pri) >= $signed(ent[1].pri)))
		else $error("chain out of order");

	// a completed insert grows the count by one
	a_ins_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("insert did not bump count");

	// an inserted job with the top priority lands at the head
	a_ins_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins && !gt[0]) |=> (ent[0].tag == $past(job_tag)))
		else $error("top priority job not at head");

	// a refused command leaves the count alone
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !cmd.ins && !cmd.rem) |=> $stable(cnt_q))
		else $error("refused command changed count");

endmodule
